// ----- design/mst_pkg.sv -----
// shared types and constants for the multi-slot repeat timer
// no dependencies

package mst_pkg;

    typedef enum logic [1:0] {
        K_ADD   = 2'd0,
        K_CLEAR = 2'd1,
        K_TICK  = 2'd2,
        K_FLUSH = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        EV_ADDED       = 3'd0,
        EV_FULL        = 3'd1,
        EV_CLEARED     = 3'd2,
        EV_CLEAR_EMPTY = 3'd3,
        EV_FIRED       = 3'd4,
        EV_FLUSHED     = 3'd5,
        EV_DONE        = 3'd6
    } t_event;

    localparam logic signed [15:0] FOREVER = -16'sd1;

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 8;

    typedef struct packed {
        t_kind              kind;
        logic [31:0]        now_time;
        logic [31:0]        period;
        logic signed [15:0] repeat_count;
        logic [2:0]         slot_index;
        logic               index_ok;
    } t_cmd;

    typedef struct packed {
        t_event     event_res;
        logic [2:0] slot;
        logic       expired;
        logic       last;
    } t_res;

endpackage

// ----- design/mst_front.sv -----
// front end: accepts input transfers, decodes them into commands and queues them
// depends on mst_pkg

module mst_front #(
    parameter int SLOTS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [mst_pkg::IN_DATA_W-1:0] i_s_tdata,
    input  logic [1:0]                    i_s_tuser,
    output logic                          o_q_valid,
    output mst_pkg::t_cmd                 o_q_cmd,
    input  logic                          i_q_pop
);

    mst_pkg::t_cmd r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          n_wp, n_rp;
    logic [1:0]    n_cnt;
    logic          push;
    logic          pop;
    mst_pkg::t_cmd cmd_in;

    always_comb begin
        cmd_in.kind         = mst_pkg::t_kind'(i_s_tuser);
        cmd_in.now_time     = i_s_tdata[31:0];
        cmd_in.period       = i_s_tdata[63:32];
        cmd_in.repeat_count = $signed(i_s_tdata[79:64]);
        cmd_in.slot_index   = i_s_tdata[82:80];
        cmd_in.index_ok     = (32'(i_s_tdata[82:80]) < 32'(SLOTS));
    end

    assign o_s_tready = (r_cnt != 2'd2);
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_cmd    = r_q[r_rp];
    assign push       = i_s_tvalid && o_s_tready;
    assign pop        = i_q_pop && o_q_valid;

    always_comb begin
        n_wp  = push ? ~r_wp : r_wp;
        n_rp  = pop ? ~r_rp : r_rp;
        n_cnt = r_cnt + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

endmodule

// ----- design/mst_back.sv -----
// back end: slot table, sequencer over the slots and output register
// depends on mst_pkg

module mst_back #(
    parameter int SLOTS     = 8,
    parameter int TIME_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    input  mst_pkg::t_cmd i_q_cmd,
    output logic          o_q_pop,
    output logic          o_out_valid,
    output mst_pkg::t_res o_out,
    input  logic          i_out_ready
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam int EW = 32 + TIME_BITS + 16;
    localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_CLR,
        S_RD,
        S_EV,
        S_DONE
    } t_state;

    t_state        r_state, n_state;
    mst_pkg::t_cmd r_cmd, n_cmd;
    logic [SW-1:0] r_idx, n_idx;
    logic [SLOTS-1:0] r_valid, n_valid;
    logic          r_out_valid, n_out_valid;
    mst_pkg::t_res r_out, n_out;
    logic [EW-1:0] r_mem [SLOTS];
    logic [EW-1:0] r_rd;

    logic                 mem_we;
    logic [EW-1:0]        mem_wdata;
    logic                 out_free;
    logic                 at_last;
    logic [TIME_BITS-1:0] now_t;
    logic [31:0]          ent_per;
    logic [TIME_BITS-1:0] ent_last;
    logic signed [15:0]   ent_rem;
    logic signed [15:0]   rem_new;
    logic [TIME_BITS-1:0] elapsed;
    logic                 is_forever;
    logic                 fire;
    logic                 flush_hit;
    logic                 fire_exp;
    logic                 act;
    logic [SW-1:0]        clr_idx;

    assign out_free   = !r_out_valid || i_out_ready;
    assign at_last    = (r_idx == LAST_SLOT);
    assign now_t      = TIME_BITS'(r_cmd.now_time);
    assign ent_per    = r_rd[31:0];
    assign ent_last   = r_rd[32 +: TIME_BITS];
    assign ent_rem    = $signed(r_rd[EW-1 -: 16]);
    assign elapsed    = now_t - ent_last;
    assign is_forever = (ent_rem == mst_pkg::FOREVER);
    assign fire       = r_valid[r_idx] && (CW'(elapsed) >= CW'(ent_per));
    assign flush_hit  = r_valid[r_idx] && !is_forever && (ent_rem <= 16'sd0);
    assign fire_exp   = !is_forever && (ent_rem <= 16'sd1);
    assign rem_new    = (is_forever || fire_exp) ? ent_rem : ent_rem - 16'sd1;
    assign act        = (r_cmd.kind == mst_pkg::K_TICK) ? fire : flush_hit;
    assign clr_idx    = SW'(r_cmd.slot_index);

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_valid     = r_valid;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        mem_we      = 1'b0;
        mem_wdata   = {r_cmd.repeat_count, now_t, r_cmd.period};
        o_q_pop     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_idx   = '0;
                    unique case (i_q_cmd.kind)
                        mst_pkg::K_ADD:   n_state = S_ADD;
                        mst_pkg::K_CLEAR: n_state = S_CLR;
                        mst_pkg::K_TICK,
                        mst_pkg::K_FLUSH: n_state = S_RD;
                        default:          n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD: begin
                if (!r_valid[r_idx]) begin
                    if (out_free) begin
                        mem_we         = 1'b1;
                        n_valid[r_idx] = 1'b1;
                        n_out_valid    = 1'b1;
                        n_out          = '{mst_pkg::EV_ADDED, 3'(r_idx), 1'b0, 1'b1};
                        n_state        = S_IDLE;
                    end
                end else if (at_last) begin
                    if (out_free) begin
                        n_out_valid = 1'b1;
                        n_out       = '{mst_pkg::EV_FULL, 3'd0, 1'b0, 1'b1};
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_CLR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (r_cmd.index_ok && r_valid[clr_idx]) begin
                        n_valid[clr_idx] = 1'b0;
                        n_out = '{mst_pkg::EV_CLEARED, r_cmd.slot_index, 1'b0, 1'b1};
                    end else begin
                        n_out = '{mst_pkg::EV_CLEAR_EMPTY, r_cmd.slot_index, 1'b0, 1'b1};
                    end
                end
            end
            S_RD: begin
                n_state = S_EV;
            end
            S_EV: begin
                if (!act || out_free) begin
                    if (act) begin
                        n_out_valid = 1'b1;
                        if (r_cmd.kind == mst_pkg::K_TICK) begin
                            mem_we    = 1'b1;
                            mem_wdata = {rem_new, now_t, ent_per};
                            n_out     = '{mst_pkg::EV_FIRED, 3'(r_idx), fire_exp, 1'b0};
                            if (fire_exp) begin
                                n_valid[r_idx] = 1'b0;
                            end
                        end else begin
                            n_valid[r_idx] = 1'b0;
                            n_out = '{mst_pkg::EV_FLUSHED, 3'(r_idx), 1'b0, 1'b0};
                        end
                    end
                    if (at_last) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{mst_pkg::EV_DONE, 3'd0, 1'b0, 1'b1};
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
        r_cmd <= n_cmd;
        r_idx <= n_idx;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_idx] <= mem_wdata;
        end
        if (r_state == S_RD) begin
            r_rd <= r_mem[r_idx];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ----- design/multi_slot_repeat_timer.sv -----
// top level of the multi-slot repeat timer: front decoder/queue and back sequencer
// depends on mst_pkg, mst_front, mst_back
//
//  channel  dir  handshake                 payload
//  s        in   i_s_tvalid / o_s_tready   i_s_tdata, i_s_tuser (kind)
//  m        out  o_m_tvalid / i_m_tready   o_m_tdata, o_m_tlast
//
// add: a scan of the valid bits for the first free slot, clear: a check of the named slot
// tick and flush: one table read and one evaluation per slot, then the done result
// a two-entry command queue takes new transfers while the back end is busy
// reset (i_rst_n low, synchronous) empties the table and the queue
// a stalled output holds the back end at the next result

module multi_slot_repeat_timer #(
    parameter int SLOTS     = 8,
    parameter int TIME_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // now_time[31:0], period[63:32], repeat_count[79:64], slot_index[82:80], zero
    input  logic [mst_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // kind[1:0]
    input  logic [1:0]                     i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // event_res[2:0], slot[5:3], expired[6], zero
    output logic [mst_pkg::OUT_DATA_W-1:0] o_m_tdata,
    output logic                           o_m_tlast
);

    logic          q_valid;
    mst_pkg::t_cmd q_cmd;
    logic          q_pop;
    mst_pkg::t_res res;

    mst_front #(
        .SLOTS(SLOTS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_q_valid  (q_valid),
        .o_q_cmd    (q_cmd),
        .i_q_pop    (q_pop)
    );

    mst_back #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_m_tvalid),
        .o_out       (res),
        .i_out_ready (i_m_tready)
    );

    assign o_m_tdata = {1'b0, res.expired, res.slot, res.event_res};
    assign o_m_tlast = res.last;

endmodule

// ----- design/mst_checker.sv -----
// port-level checks for the multi-slot repeat timer, bound to the top level
// depends on mst_pkg, multi_slot_repeat_timer

module mst_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_s_tvalid,
    input logic                           o_s_tready,
    input logic [mst_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input logic [1:0]                     i_s_tuser,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [mst_pkg::OUT_DATA_W-1:0] o_m_tdata,
    input logic                           o_m_tlast
);

    logic [2:0] ev;
    assign ev = o_m_tdata[2:0];

    a_slot_events_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (ev == mst_pkg::EV_FIRED || ev == mst_pkg::EV_FLUSHED) |-> !o_m_tlast)
        else $error("per-slot event marked last");

    a_other_events_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> ev == mst_pkg::EV_FIRED || ev == mst_pkg::EV_FLUSHED)
        else $error("final event without tlast");

    a_expired_only_fired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[6] |-> ev == mst_pkg::EV_FIRED)
        else $error("expired flag on non-fired event");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (ev == mst_pkg::EV_FULL || ev == mst_pkg::EV_DONE)
        |-> o_m_tdata[5:3] == 3'd0)
        else $error("full or done with nonzero slot");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled output transfer changed");

endmodule

bind multi_slot_repeat_timer mst_checker u_mst_checker (.*);

// ----- dv/multi_slot_repeat_timer_tb.sv -----
// self-checking testbench for multi_slot_repeat_timer: directed and random add, clear,
// tick and flush commands checked against an in-bench model of the slot table
// depends on mst_pkg and the multi_slot_repeat_timer rtl
`timescale 1ns / 100ps

module multi_slot_repeat_timer_tb;

    localparam int SLOTS          = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 2 * SLOTS + 4;

    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [mst_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
    logic [1:0]                     s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [mst_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           m_tlast;

    // table model
    logic                     tbl_valid [SLOTS];
    logic [31:0]              tbl_period [SLOTS];
    logic [31:0]              tbl_fired [SLOTS];
    logic signed [15:0]       tbl_count [SLOTS];

    mst_pkg::t_res pending_events [$];
    int          err_cnt     = 0;
    int          kind_seen [4];
    int          result_cnt  = 0;
    int          fire_cnt    = 0;
    int          expire_cnt  = 0;
    int          full_cnt    = 0;
    int          quiet_cycles = 0;
    bit          idle_on     = 1'b1;
    logic [31:0] wall_ms     = '0;

    always #5 clk = ~clk;

    multi_slot_repeat_timer #(
        .SLOTS     (SLOTS),
        .TIME_BITS (32)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    function automatic mst_pkg::t_res make_event(mst_pkg::t_event ev, logic [2:0] slot,
                                                 logic expired, logic last);
        mst_pkg::t_res r;
        r.event_res = ev;
        r.slot      = slot;
        r.expired   = expired;
        r.last      = last;
        return r;
    endfunction

    task automatic queue_event(input mst_pkg::t_res r);
        pending_events.insert(pending_events.size(), r);
    endtask

    task automatic predict_events(input mst_pkg::t_kind kind, input logic [31:0] now,
                                  input logic [31:0] per, input logic signed [15:0] cnt,
                                  input logic [2:0] idx);
        int          free_slot;
        logic [31:0] elapsed;
        logic        gone;
        free_slot = -1;
        unique case (kind)
            mst_pkg::K_ADD: begin
                for (int i = 0; i < SLOTS; i++)
                    if (!tbl_valid[i] && free_slot < 0) free_slot = i;
                if (free_slot >= 0) begin
                    tbl_valid[free_slot]  = 1'b1;
                    tbl_period[free_slot] = per;
                    tbl_fired[free_slot]  = now;
                    tbl_count[free_slot]  = cnt;
                    queue_event(make_event(mst_pkg::EV_ADDED, 3'(free_slot), 1'b0, 1'b1));
                end else begin
                    full_cnt++;
                    queue_event(make_event(mst_pkg::EV_FULL, 3'd0, 1'b0, 1'b1));
                end
            end
            mst_pkg::K_CLEAR: begin
                if (tbl_valid[idx]) begin
                    tbl_valid[idx] = 1'b0;
                    queue_event(make_event(mst_pkg::EV_CLEARED, idx, 1'b0, 1'b1));
                end else begin
                    queue_event(make_event(mst_pkg::EV_CLEAR_EMPTY, idx, 1'b0, 1'b1));
                end
            end
            mst_pkg::K_TICK: begin
                for (int i = 0; i < SLOTS; i++) begin
                    elapsed = now - tbl_fired[i];
                    if (tbl_valid[i] && elapsed >= tbl_period[i]) begin
                        gone         = 1'b0;
                        tbl_fired[i] = now;
                        if (tbl_count[i] != mst_pkg::FOREVER) begin
                            if (tbl_count[i] <= 16'sd1) begin
                                gone         = 1'b1;
                                tbl_valid[i] = 1'b0;
                            end else begin
                                tbl_count[i] = tbl_count[i] - 16'sd1;
                            end
                        end
                        fire_cnt++;
                        if (gone) expire_cnt++;
                        queue_event(make_event(mst_pkg::EV_FIRED, 3'(i), gone, 1'b0));
                    end
                end
                queue_event(make_event(mst_pkg::EV_DONE, 3'd0, 1'b0, 1'b1));
            end
            default: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (tbl_valid[i] && tbl_count[i] != mst_pkg::FOREVER &&
                        tbl_count[i] <= 16'sd0) begin
                        tbl_valid[i] = 1'b0;
                        queue_event(make_event(mst_pkg::EV_FLUSHED, 3'(i), 1'b0, 1'b0));
                    end
                end
                queue_event(make_event(mst_pkg::EV_DONE, 3'd0, 1'b0, 1'b1));
            end
        endcase
    endtask

    // called at a rising edge; returns at the edge where the transfer happens
    task automatic send_cmd(input mst_pkg::t_kind kind, input logic [31:0] now,
                            input logic [31:0] per, input logic signed [15:0] cnt,
                            input logic [2:0] idx);
        int gap;
        gap = (idle_on && $urandom_range(99) < 6) ? $urandom_range(4, 1) : 0;
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {5'b0, idx, cnt, per, now};
        do @(posedge clk); while (!s_tready);
        predict_events(kind, now, per, cnt, idx);
        kind_seen[kind]++;
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_events.size() != 0);
    endtask

    task automatic send_random_cmd();
        int                 pick;
        logic [31:0]        per;
        logic signed [15:0] cnt;
        pick = $urandom_range(99);
        if (pick < 30) begin
            case ($urandom_range(9))
                0:       per = $urandom;
                1, 2:    per = $urandom_range(2000);
                default: per = $urandom_range(40);
            endcase
            case ($urandom_range(9))
                0, 1, 2: cnt = mst_pkg::FOREVER;
                3:       cnt = 16'($urandom);
                default: cnt = 16'($urandom_range(4));
            endcase
            send_cmd(mst_pkg::K_ADD, wall_ms, per, cnt, 3'($urandom));
        end else if (pick < 42) begin
            send_cmd(mst_pkg::K_CLEAR, $urandom, $urandom, 16'($urandom), 3'($urandom));
        end else if (pick < 85) begin
            if ($urandom_range(19) == 0) wall_ms = $urandom;
            else wall_ms = wall_ms + $urandom_range(30);
            send_cmd(mst_pkg::K_TICK, wall_ms, $urandom, 16'($urandom), 3'($urandom));
        end else begin
            send_cmd(mst_pkg::K_FLUSH, $urandom, $urandom, 16'($urandom), 3'($urandom));
        end
    endtask

    task automatic test_add_and_clear();
        send_cmd(mst_pkg::K_ADD, 32'h0, 32'h0, mst_pkg::FOREVER, 3'd0);
        send_cmd(mst_pkg::K_CLEAR, 32'h0, 32'h0, 16'sd0, 3'd0);
        send_cmd(mst_pkg::K_CLEAR, 32'h0, 32'h0, 16'sd0, 3'd0);
        send_cmd(mst_pkg::K_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, -16'sd1, 3'd7);
        send_cmd(mst_pkg::K_TICK, 32'hFFFF_FFFF, 32'h0, 16'sd0, 3'd0);
    endtask

    // fill the table with extreme periods and counts, overfill it, then flush and tick across the time wrap
    task automatic test_full_table();
        send_cmd(mst_pkg::K_ADD, 32'hFFFF_FFF0, 32'h0,         mst_pkg::FOREVER, 3'd0);
        send_cmd(mst_pkg::K_ADD, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 16'sd32767,       3'd0);
        send_cmd(mst_pkg::K_ADD, 32'hFFFF_FFF0, 32'd16,        16'sd1,           3'd0);
        send_cmd(mst_pkg::K_ADD, 32'hFFFF_FFF0, 32'd5,         16'sd0,           3'd0);
        send_cmd(mst_pkg::K_ADD, 32'hFFFF_FFF0, 32'd32,        -16'sd32768,      3'd0);
        send_cmd(mst_pkg::K_ADD, 32'hFFFF_FFF0, 32'h0,         16'sd2,           3'd0);
        send_cmd(mst_pkg::K_ADD, 32'hFFFF_FFF0, 32'd17,        -16'sd5,          3'd0);
        send_cmd(mst_pkg::K_ADD, 32'hFFFF_FFF0, 32'd100,       16'sd3,           3'd0);
        send_cmd(mst_pkg::K_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, mst_pkg::FOREVER, 3'd7);
        send_cmd(mst_pkg::K_FLUSH, 32'h0, 32'h0, 16'sd0, 3'd0);
        send_cmd(mst_pkg::K_TICK, 32'h0, 32'h0, 16'sd0, 3'd0);
        send_cmd(mst_pkg::K_TICK, 32'h0, 32'h0, 16'sd0, 3'd0);
        send_cmd(mst_pkg::K_FLUSH, 32'h0, 32'h0, 16'sd0, 3'd0);
    endtask

    // the table emptied slot by slot, then a zero count added and fired by a tick
    task automatic test_count_edges();
        for (int i = 0; i < SLOTS; i++)
            send_cmd(mst_pkg::K_CLEAR, 32'h0, 32'h0, 16'sd0, 3'(i));
        send_cmd(mst_pkg::K_ADD, 32'h8000_0000, 32'h8000_0000, 16'sd0, 3'd0);
        send_cmd(mst_pkg::K_TICK, 32'h0, 32'h0, 16'sd0, 3'd0);
    endtask

    task automatic test_random_traffic(input int n);
        wall_ms = 32'hFFFF_FF00;
        repeat (n) send_random_cmd();
    endtask

    task automatic test_back_to_back(input int n);
        idle_on = 1'b0;
        repeat (n) send_random_cmd();
        wait_all_results();
        idle_on = 1'b1;
    endtask

    task automatic check_result();
        mst_pkg::t_res want;
        result_cnt++;
        if (pending_events.size() == 0) begin
            $error("unexpected result tdata=%h tlast=%b", m_tdata, m_tlast);
            err_cnt++;
        end else begin
            want = pending_events.pop_front();
            if (m_tdata[2:0] !== 3'(want.event_res)) begin
                $error("event_res expected %0d actual %0d", want.event_res, m_tdata[2:0]);
                err_cnt++;
            end
            if (m_tdata[5:3] !== want.slot) begin
                $error("slot expected %0d actual %0d", want.slot, m_tdata[5:3]);
                err_cnt++;
            end
            if (m_tdata[6] !== want.expired) begin
                $error("expired expected %0d actual %0d", want.expired, m_tdata[6]);
                err_cnt++;
            end
            if (m_tdata[7] !== 1'b0) begin
                $error("pad expected 0 actual %0d", m_tdata[7]);
                err_cnt++;
            end
            if (m_tlast !== want.last) begin
                $error("last expected %0d actual %0d", want.last, m_tlast);
                err_cnt++;
            end
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_result();
            m_tready <= !idle_on || ($urandom_range(99) >= 6);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("multi_slot_repeat_timer_tb: FAIL");
                $finish;
            end
        end
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) tbl_valid[i] = 1'b0;
        for (int k = 0; k < 4; k++) kind_seen[k] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_add_and_clear();
        test_full_table();
        test_count_edges();
        wait_all_results();
        test_random_traffic(130);
        wait_all_results();
        test_back_to_back(60);
        test_random_traffic(40);

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_events.size() != 0) begin
            $error("%0d expected results never arrived", pending_events.size());
            err_cnt++;
        end

        $display("covered %0d add, %0d clear, %0d tick, %0d flush commands, %0d results",
                 kind_seen[mst_pkg::K_ADD], kind_seen[mst_pkg::K_CLEAR],
                 kind_seen[mst_pkg::K_TICK], kind_seen[mst_pkg::K_FLUSH], result_cnt);
        $display("with %0d firings, %0d expiries and %0d table-full replies",
                 fire_cnt, expire_cnt, full_cnt);
        if (err_cnt == 0)
            $display("multi_slot_repeat_timer_tb: PASS");
        else
            $display("multi_slot_repeat_timer_tb: FAIL");
        $finish;
    end

endmodule

// ----- multi_slot_repeat_timer.f -----
design/mst_pkg.sv
design/mst_front.sv
design/mst_back.sv
design/multi_slot_repeat_timer.sv
design/mst_checker.sv
dv/multi_slot_repeat_timer_tb.sv
